/* rtl/ipcf_pkg.sv */
// Shared types, character codes and glyph functions of the address text formatter.
// Used by the zero-run scanner, the digit unit and the top level; depends on nothing.
package ipcf_pkg;

    localparam logic [1:0] FAM_UNSPEC = 2'd0;
    localparam logic [1:0] FAM_IPV4   = 2'd1;

    localparam logic [15:0] MAPPED_GROUP = 16'hFFFF;
    localparam logic [2:0]  PREFIX_LAST  = 3'd6;

    localparam logic [6:0] CH_NUL   = 7'h00;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_A     = 7'h61;
    localparam logic [6:0] CH_F     = 7'h66;
    localparam logic [6:0] CH_COLON = 7'h3A;
    localparam logic [6:0] CH_DOT   = 7'h2E;

    // Outcome of the zero-run scan over the eight groups.
    typedef struct packed {
        logic       done;
        logic [2:0] top_start;
        logic [3:0] top_len;
    } t_scan;

    // One digit of the value in the digit unit.
    typedef struct packed {
        logic [6:0] glyph;
        logic [1:0] last_idx;
    } t_digit;

    function automatic logic [6:0] hex_glyph(input logic [3:0] n);
        logic [6:0] c;
        if (n < 4'd10) begin
            c = CH_ZERO + {3'b000, n};
        end else begin
            c = CH_A + {3'b000, n} - 7'd10;
        end
        return c;
    endfunction

    // The fixed text "::ffff:" that opens an IPv4-mapped address.
    function automatic logic [6:0] prefix_glyph(input logic [2:0] idx);
        logic [6:0] c;
        unique case (idx)
            3'd2, 3'd3, 3'd4, 3'd5: c = CH_F;
            default:                c = CH_COLON;
        endcase
        return c;
    endfunction

endpackage

/* rtl/ipcf_zero_scan.sv */
// Iterative scan for the longest run of zero groups in an IPv6 address, one group a cycle.
// Depends on ipcf_pkg for the result struct.
module ipcf_zero_scan (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [127:0]         i_addr,
    output ipcf_pkg::t_scan      o_scan
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [2:0]  r_idx, n_idx;
    logic [3:0]  r_cur_len, n_cur_len;
    logic [2:0]  r_cur_start, n_cur_start;
    logic [3:0]  r_top_len, n_top_len;
    logic [2:0]  r_top_start, n_top_start;
    logic [15:0] w_group;

    assign w_group = i_addr[{~r_idx, 4'b0000} +: 16];

    always_comb begin
        n_busy      = r_busy;
        n_done      = 1'b0;
        n_idx       = r_idx;
        n_cur_len   = r_cur_len;
        n_cur_start = r_cur_start;
        n_top_len   = r_top_len;
        n_top_start = r_top_start;
        if (i_start) begin
            n_busy      = 1'b1;
            n_idx       = 3'd0;
            n_cur_len   = 4'd0;
            n_cur_start = 3'd0;
            n_top_len   = 4'd0;
            n_top_start = 3'd0;
        end else if (r_busy) begin
            if (w_group == 16'h0000) begin
                n_cur_start = (r_cur_len == 4'd0) ? r_idx : r_cur_start;
                n_cur_len   = r_cur_len + 4'd1;
                // Strictly longer only, so the earliest run keeps a tie.
                if (n_cur_len > r_top_len) begin
                    n_top_len   = n_cur_len;
                    n_top_start = n_cur_start;
                end
            end else begin
                n_cur_len = 4'd0;
            end
            if (r_idx == 3'd7) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
            n_idx = r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
            r_idx       <= 3'd0;
            r_cur_len   <= 4'd0;
            r_cur_start <= 3'd0;
            r_top_len   <= 4'd0;
            r_top_start <= 3'd0;
        end else begin
            r_busy      <= n_busy;
            r_done      <= n_done;
            r_idx       <= n_idx;
            r_cur_len   <= n_cur_len;
            r_cur_start <= n_cur_start;
            r_top_len   <= n_top_len;
            r_top_start <= n_top_start;
        end
    end

    assign o_scan.done      = r_done;
    assign o_scan.top_start = r_top_start;
    assign o_scan.top_len   = r_top_len;

endmodule

/* rtl/ipcf_digit_unit.sv */
// Shared digit unit: yields one decimal or hex digit glyph of a value and the index of its last digit.
// Depends on ipcf_pkg for the glyph function and the result struct.
module ipcf_digit_unit (
    input  logic                 i_hex,
    input  logic [15:0]          i_value,
    input  logic [1:0]           i_sel,
    output ipcf_pkg::t_digit     o_digit
);

    logic [7:0]  w_oct;
    logic [1:0]  w_hund;
    logic [7:0]  w_rem8;
    logic [6:0]  w_rem;
    logic [14:0] w_prod;
    logic [3:0]  w_tens;
    logic [6:0]  w_ones7;
    logic [1:0]  w_last_idx;
    logic [1:0]  w_pos;
    logic [3:0]  w_dec_digit;
    logic [3:0]  w_nibble;

    assign w_oct  = i_value[7:0];
    assign w_hund = (w_oct >= 8'd200) ? 2'd2 : ((w_oct >= 8'd100) ? 2'd1 : 2'd0);
    assign w_rem8 = w_oct - ((w_hund == 2'd2) ? 8'd200 : ((w_hund == 2'd1) ? 8'd100 : 8'd0));
    assign w_rem  = w_rem8[6:0];
    // Tens of a value below 100 by multiplying with 205/2048.
    assign w_prod  = {8'b0, w_rem} * 15'd205;
    assign w_tens  = w_prod[14:11];
    assign w_ones7 = w_rem - 7'({3'b000, w_tens} * 7'd10);

    always_comb begin
        if (i_hex) begin
            if (i_value[15:12] != 4'h0) begin
                w_last_idx = 2'd3;
            end else if (i_value[11:8] != 4'h0) begin
                w_last_idx = 2'd2;
            end else if (i_value[7:4] != 4'h0) begin
                w_last_idx = 2'd1;
            end else begin
                w_last_idx = 2'd0;
            end
        end else begin
            if (w_oct >= 8'd100) begin
                w_last_idx = 2'd2;
            end else if (w_oct >= 8'd10) begin
                w_last_idx = 2'd1;
            end else begin
                w_last_idx = 2'd0;
            end
        end
    end

    // The sequencer counts digits from the most significant one.
    assign w_pos    = w_last_idx - i_sel;
    assign w_nibble = i_value[{w_pos, 2'b00} +: 4];

    always_comb begin
        unique case (w_pos)
            2'd2:    w_dec_digit = {2'b00, w_hund};
            2'd1:    w_dec_digit = w_tens;
            default: w_dec_digit = w_ones7[3:0];
        endcase
    end

    assign o_digit.glyph    = i_hex ? ipcf_pkg::hex_glyph(w_nibble)
                                    : (ipcf_pkg::CH_ZERO + {3'b000, w_dec_digit});
    assign o_digit.last_idx = w_last_idx;

endmodule

/* rtl/ip_address_canonical_formatter_unit.sv */
// Output: the first character is registered from the first state after the request is taken
// (IPv4, IPv4-mapped, error) or after the zero-run scan completes (IPv6).
// Requests: one at a time; the next request is taken only after the last character of this
// one has been handed to the output register, and the output can stall the character loop.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle and empties the output.
// Depends on ipcf_pkg, ipcf_zero_scan and ipcf_digit_unit.
module ip_address_canonical_formatter_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // address_high [63:0], address_low [127:64]
    input  logic [1:0]   s_axis_tuser,   // family [1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,   // character [6:0], zero [7]
    output logic         m_axis_tlast,
    output logic         m_axis_tuser    // error [0]
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ERR    = 3'd1;
    localparam logic [2:0] ST_PREFIX = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_HEX    = 3'd4;
    localparam logic [2:0] ST_GAP    = 3'd5;
    localparam logic [2:0] ST_DEC    = 3'd6;

    logic [2:0]   r_state, n_state;
    logic [2:0]   r_fld, n_fld;
    logic [1:0]   r_dig, n_dig;
    logic         r_sep, n_sep;
    logic [127:0] r_addr;
    logic         r_out_valid;
    logic [6:0]   r_out_char;
    logic         r_out_last;
    logic         r_out_err;

    logic            w_out_free;
    logic            w_emit;
    logic [6:0]      w_char;
    logic            w_last;
    logic            w_err;
    logic            w_scan_start;
    logic            w_run_hit;
    logic [3:0]      w_run_end;
    logic [15:0]     w_value;
    logic            w_is_mapped;
    ipcf_pkg::t_scan  w_scan;
    ipcf_pkg::t_digit w_digit;

    ipcf_zero_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_scan_start),
        .i_addr  (r_addr),
        .o_scan  (w_scan)
    );

    ipcf_digit_unit u_digit (
        .i_hex   (r_state == ST_HEX),
        .i_value (w_value),
        .i_sel   (r_dig),
        .o_digit (w_digit)
    );

    assign w_value = (r_state == ST_HEX) ? r_addr[{~r_fld, 4'b0000} +: 16]
                                         : {8'b0, r_addr[{~r_fld[1:0], 3'b000} +: 8]};

    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_run_hit   = (w_scan.top_len >= 4'd2) && (r_fld == w_scan.top_start);
    assign w_run_end   = {1'b0, w_scan.top_start} + w_scan.top_len;
    assign w_is_mapped = (s_axis_tdata[63:0] == 64'd0) && (s_axis_tdata[127:112] == 16'h0000)
                         && (s_axis_tdata[111:96] == ipcf_pkg::MAPPED_GROUP);

    assign s_axis_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state      = r_state;
        n_fld        = r_fld;
        n_dig        = r_dig;
        n_sep        = r_sep;
        w_emit       = 1'b0;
        w_char       = ipcf_pkg::CH_NUL;
        w_last       = 1'b0;
        w_err        = 1'b0;
        w_scan_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_fld = 3'd0;
                    n_dig = 2'd0;
                    n_sep = 1'b0;
                    if (s_axis_tuser == ipcf_pkg::FAM_UNSPEC) begin
                        n_state = ST_ERR;
                    end else if (s_axis_tuser == ipcf_pkg::FAM_IPV4) begin
                        n_state = ST_DEC;
                    end else if (w_is_mapped) begin
                        n_state = ST_PREFIX;
                    end else begin
                        // The scanner only clears itself on this edge; it reads the
                        // captured address from the next cycle on.
                        n_state      = ST_SCAN;
                        w_scan_start = 1'b1;
                    end
                end
            end
            ST_ERR: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    w_last  = 1'b1;
                    w_err   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_PREFIX: begin
                if (w_out_free) begin
                    w_emit = 1'b1;
                    w_char = ipcf_pkg::prefix_glyph(r_fld);
                    if (r_fld == ipcf_pkg::PREFIX_LAST) begin
                        n_state = ST_DEC;
                        n_fld   = 3'd0;
                    end else begin
                        n_fld = r_fld + 3'd1;
                    end
                end
            end
            ST_SCAN: begin
                if (w_scan.done) begin
                    n_state = ST_HEX;
                end
            end
            ST_HEX: begin
                if (w_run_hit) begin
                    n_state = ST_GAP;
                    n_dig   = 2'd0;
                end else if (w_out_free) begin
                    w_emit = 1'b1;
                    if (r_sep) begin
                        w_char = ipcf_pkg::CH_COLON;
                        n_sep  = 1'b0;
                        n_dig  = 2'd0;
                        n_fld  = r_fld + 3'd1;
                    end else begin
                        w_char = w_digit.glyph;
                        if (r_dig == w_digit.last_idx) begin
                            if (r_fld == 3'd7) begin
                                w_last  = 1'b1;
                                n_state = ST_IDLE;
                            end else begin
                                n_sep = 1'b1;
                            end
                        end else begin
                            n_dig = r_dig + 2'd1;
                        end
                    end
                end
            end
            ST_GAP: begin
                if (w_out_free) begin
                    w_emit = 1'b1;
                    w_char = ipcf_pkg::CH_COLON;
                    // A run at the start needs both colons; otherwise the group before
                    // it already wrote the first one.
                    if ((r_dig == 2'd1) || (w_scan.top_start != 3'd0)) begin
                        if (w_run_end == 4'd8) begin
                            w_last  = 1'b1;
                            n_state = ST_IDLE;
                        end else begin
                            n_state = ST_HEX;
                            n_fld   = w_run_end[2:0];
                            n_dig   = 2'd0;
                            n_sep   = 1'b0;
                        end
                    end else begin
                        n_dig = r_dig + 2'd1;
                    end
                end
            end
            ST_DEC: begin
                if (w_out_free) begin
                    w_emit = 1'b1;
                    if (r_sep) begin
                        w_char = ipcf_pkg::CH_DOT;
                        n_sep  = 1'b0;
                        n_dig  = 2'd0;
                        n_fld  = r_fld + 3'd1;
                    end else begin
                        w_char = w_digit.glyph;
                        if (r_dig == w_digit.last_idx) begin
                            if (r_fld == 3'd3) begin
                                w_last  = 1'b1;
                                n_state = ST_IDLE;
                            end else begin
                                n_sep = 1'b1;
                            end
                        end else begin
                            n_dig = r_dig + 2'd1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fld       <= 3'd0;
            r_dig       <= 2'd0;
            r_sep       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fld   <= n_fld;
            r_dig   <= n_dig;
            r_sep   <= n_sep;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_addr <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
        end
        if (w_emit) begin
            r_out_char <= w_char;
            r_out_last <= w_last;
            r_out_err  <= w_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_char};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_err;

    a_err_is_lone_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_last && (r_out_char == ipcf_pkg::CH_NUL)))
        else $error("error result is not a lone NUL marked last");

    a_one_request_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while the previous one is still in work");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last) |=> (r_state == ST_IDLE))
        else $error("sequencer kept running after the final character");

    a_scan_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan.done |-> (r_state == ST_SCAN))
        else $error("zero-run scan finished outside the scan phase");

endmodule
